// ===== src/bbw_pkg.sv =====
// Shared types and codes for the bounded buffer with waiter queues.
package bbw_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int WAIT_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF   = 8;
    localparam int ITEM_BITS_DEF  = 32;

    localparam logic [1:0] REQ_PRODUCE = 2'd0;
    localparam logic [1:0] REQ_CONSUME = 2'd1;
    localparam logic [1:0] REQ_REMOVE  = 2'd2;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_PURGE = 2'd2;

    localparam logic SEL_SPACE = 1'b0;
    localparam logic SEL_DATA  = 1'b1;

    typedef struct packed {
        logic       go;
        logic [1:0] op;
        logic       sel;
    } t_wq_cmd;

    typedef struct packed {
        logic done;
        logic found;
    } t_wq_rsp;

endpackage

// ===== src/bbw_waiters.sv =====
// Two waiter rings in one memory with a shared scan and compaction sequencer.
module bbw_waiters #(
    parameter int WAIT_DEPTH = bbw_pkg::WAIT_DEPTH_DEF,
    parameter int PID_BITS   = bbw_pkg::PID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbw_pkg::t_wq_cmd    i_cmd,
    input  logic [PID_BITS-1:0] i_pid,
    output bbw_pkg::t_wq_rsp    o_rsp,
    output logic [PID_BITS-1:0] o_pid
);
    import bbw_pkg::*;

    localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam logic [WW-1:0] LAST = WW'(WAIT_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(WAIT_DEPTH);

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_POP   = 2'd1;
    localparam logic [1:0] W_SCAN  = 2'd2;
    localparam logic [1:0] W_PURGE = 2'd3;

    logic [PID_BITS-1:0] r_mem [2][WAIT_DEPTH];
    logic [PID_BITS-1:0] r_rd;

    logic [1:0]          r_state, n_state;
    logic                r_sel, n_sel;
    logic [PID_BITS-1:0] r_pid, n_pid;
    logic [WW-1:0]       r_head [2];
    logic [WW-1:0]       n_head [2];
    logic [CW-1:0]       r_cnt [2];
    logic [CW-1:0]       n_cnt [2];
    logic [WW-1:0]       r_ptr, n_ptr;
    logic [WW-1:0]       r_wptr, n_wptr;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_keep, n_keep;
    logic                r_rv, n_rv;
    logic                r_hit, n_hit;

    logic                rd_en;
    logic                rd_sel;
    logic [WW-1:0]       rd_addr;
    logic                we;
    logic [WW-1:0]       wa;
    logic [PID_BITS-1:0] wd;
    logic [CW-1:0]       cur_cnt;
    logic [WW-1:0]       cur_head;
    logic                more;

    function automatic logic [WW-1:0] wrap_inc(input logic [WW-1:0] p);
        return (p == LAST) ? '0 : WW'(p + 1'b1);
    endfunction

    assign cur_cnt  = r_cnt[r_sel];
    assign cur_head = r_head[r_sel];
    assign more     = (r_idx != cur_cnt);
    assign o_pid    = r_rd;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_pid   = r_pid;
        n_head  = r_head;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_wptr  = r_wptr;
        n_idx   = r_idx;
        n_keep  = r_keep;
        n_rv    = r_rv;
        n_hit   = r_hit;
        rd_en   = 1'b0;
        rd_sel  = r_sel;
        rd_addr = r_ptr;
        we      = 1'b0;
        wa      = r_ptr;
        wd      = r_pid;
        o_rsp   = '0;
        unique case (r_state)
            W_IDLE: begin
                if (i_cmd.go) begin
                    n_sel  = i_cmd.sel;
                    n_pid  = i_pid;
                    n_ptr  = r_head[i_cmd.sel];
                    n_wptr = r_head[i_cmd.sel];
                    n_idx  = '0;
                    n_keep = '0;
                    n_rv   = 1'b0;
                    n_hit  = 1'b0;
                    case (i_cmd.op)
                        OP_POP: begin
                            rd_en   = 1'b1;
                            rd_sel  = i_cmd.sel;
                            rd_addr = r_head[i_cmd.sel];
                            n_state = W_POP;
                        end
                        OP_PUSH: n_state = W_SCAN;
                        OP_PURGE: begin
                            n_sel   = SEL_SPACE;
                            n_ptr   = r_head[SEL_SPACE];
                            n_wptr  = r_head[SEL_SPACE];
                            n_state = W_PURGE;
                        end
                        default: n_state = W_IDLE;
                    endcase
                end
            end
            W_POP: begin
                o_rsp.done  = 1'b1;
                o_rsp.found = (cur_cnt != '0);
                if (cur_cnt != '0) begin
                    n_head[r_sel] = wrap_inc(cur_head);
                    n_cnt[r_sel]  = CW'(cur_cnt - 1'b1);
                end
                n_state = W_IDLE;
            end
            W_SCAN: begin
                rd_en = more;
                n_rv  = more;
                if (more) begin
                    n_ptr = wrap_inc(r_ptr);
                    n_idx = CW'(r_idx + 1'b1);
                end
                if (r_rv && r_rd == r_pid) begin
                    n_hit = 1'b1;
                end
                if (!more && !r_rv) begin
                    if (!r_hit && cur_cnt != FULL) begin
                        we           = 1'b1;
                        n_cnt[r_sel] = CW'(cur_cnt + 1'b1);
                    end
                    o_rsp.done = 1'b1;
                    n_state    = W_IDLE;
                end
            end
            W_PURGE: begin
                rd_en = more;
                n_rv  = more;
                if (more) begin
                    n_ptr = wrap_inc(r_ptr);
                    n_idx = CW'(r_idx + 1'b1);
                end
                if (r_rv && r_rd != r_pid) begin
                    we     = 1'b1;
                    wa     = r_wptr;
                    wd     = r_rd;
                    n_wptr = wrap_inc(r_wptr);
                    n_keep = CW'(r_keep + 1'b1);
                end
                if (!more && !r_rv) begin
                    n_cnt[r_sel] = r_keep;
                    if (r_sel == SEL_SPACE) begin
                        n_sel  = SEL_DATA;
                        n_ptr  = r_head[SEL_DATA];
                        n_wptr = r_head[SEL_DATA];
                        n_idx  = '0;
                        n_keep = '0;
                    end else begin
                        o_rsp.done = 1'b1;
                        n_state    = W_IDLE;
                    end
                end
            end
            default: n_state = W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_sel][wa] <= wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_sel][rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_sel   <= SEL_SPACE;
            r_head  <= '{default: '0};
            r_cnt   <= '{default: '0};
            r_ptr   <= '0;
            r_wptr  <= '0;
            r_idx   <= '0;
            r_keep  <= '0;
            r_rv    <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_wptr  <= n_wptr;
            r_idx   <= n_idx;
            r_keep  <= n_keep;
            r_rv    <= n_rv;
            r_hit   <= n_hit;
        end
        r_pid <= n_pid;
    end

endmodule

// ===== src/bounded_buffer_with_waiters_top.sv =====
// Top level: item ring, request decode and result register.
//
// Usage: drive i_req_type, i_pid and i_item_in with start high while busy is
// low; the request is taken at that clock edge and busy rises for the rest of
// its work, save for an undefined type. Each request yields exactly one
// result, shown on o_status, o_item_out, o_wake_valid and o_woken_pid for a
// single cycle with o_valid high. The receiver cannot stall; it must take the
// result in that cycle.
// An undefined request type is answered by the result register alone.
// Produce and consume that succeed pop a waiter head, then answer.
// A blocked request scans its waiter queue once, one entry a cycle through a
// single read port and compare, then answers.
// Remove compacts both queues through that port, space queue first.
// One request is in work at a time; the next may start in the cycle the
// result shows. Reset empties the ring and both waiter queues at once; no
// clearing pass is needed.
module bounded_buffer_with_waiters_top #(
    parameter int RING_DEPTH = bbw_pkg::RING_DEPTH_DEF,
    parameter int WAIT_DEPTH = bbw_pkg::WAIT_DEPTH_DEF,
    parameter int PID_BITS   = bbw_pkg::PID_BITS_DEF,
    parameter int ITEM_BITS  = bbw_pkg::ITEM_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_req_type,
    input  logic [PID_BITS-1:0]         i_pid,
    input  logic signed [ITEM_BITS-1:0] i_item_in,
    output logic                        o_valid,
    output logic                        o_status,
    output logic signed [ITEM_BITS-1:0] o_item_out,
    output logic                        o_wake_valid,
    output logic [PID_BITS-1:0]         o_woken_pid
);
    import bbw_pkg::*;

    localparam int RW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam logic [RW-1:0] RLAST = RW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] RFULL = FW'(RING_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAIT = 1'b1;

    logic [ITEM_BITS-1:0] r_store [RING_DEPTH];
    logic [ITEM_BITS-1:0] r_item;

    logic                 r_state, n_state;
    logic [RW-1:0]        r_wslot, n_wslot;
    logic [RW-1:0]        r_rslot, n_rslot;
    logic [FW-1:0]        r_fill, n_fill;
    logic                 r_status, n_status;
    logic                 r_use_item, n_use_item;
    logic                 r_valid, n_valid;
    logic                 r_o_status, n_o_status;
    logic [ITEM_BITS-1:0] r_o_item, n_o_item;
    logic                 r_o_wv, n_o_wv;
    logic [PID_BITS-1:0]  r_o_wp, n_o_wp;

    logic                 accept;
    logic                 st_we;
    logic                 st_re;
    t_wq_cmd              wq_cmd;
    t_wq_rsp              wq_rsp;
    logic [PID_BITS-1:0]  wq_pid;

    function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] p);
        return (p == RLAST) ? '0 : RW'(p + 1'b1);
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state    = r_state;
        n_wslot    = r_wslot;
        n_rslot    = r_rslot;
        n_fill     = r_fill;
        n_status   = r_status;
        n_use_item = r_use_item;
        n_valid    = 1'b0;
        n_o_status = r_o_status;
        n_o_item   = r_o_item;
        n_o_wv     = r_o_wv;
        n_o_wp     = r_o_wp;
        st_we      = 1'b0;
        st_re      = 1'b0;
        wq_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_use_item = 1'b0;
                    n_status   = 1'b0;
                    unique case (i_req_type)
                        REQ_PRODUCE: begin
                            wq_cmd.go = 1'b1;
                            n_state   = S_WAIT;
                            if (r_fill == RFULL) begin
                                wq_cmd.op  = OP_PUSH;
                                wq_cmd.sel = SEL_SPACE;
                                n_status   = 1'b1;
                            end else begin
                                st_we      = 1'b1;
                                n_wslot    = ring_inc(r_wslot);
                                n_fill     = FW'(r_fill + 1'b1);
                                wq_cmd.op  = OP_POP;
                                wq_cmd.sel = SEL_DATA;
                            end
                        end
                        REQ_CONSUME: begin
                            wq_cmd.go = 1'b1;
                            n_state   = S_WAIT;
                            if (r_fill == '0) begin
                                wq_cmd.op  = OP_PUSH;
                                wq_cmd.sel = SEL_DATA;
                                n_status   = 1'b1;
                            end else begin
                                st_re      = 1'b1;
                                n_use_item = 1'b1;
                                n_rslot    = ring_inc(r_rslot);
                                n_fill     = FW'(r_fill - 1'b1);
                                wq_cmd.op  = OP_POP;
                                wq_cmd.sel = SEL_SPACE;
                            end
                        end
                        REQ_REMOVE: begin
                            wq_cmd.go  = 1'b1;
                            wq_cmd.op  = OP_PURGE;
                            wq_cmd.sel = SEL_SPACE;
                            n_state    = S_WAIT;
                        end
                        default: begin
                            n_valid    = 1'b1;
                            n_o_status = 1'b0;
                            n_o_item   = '0;
                            n_o_wv     = 1'b0;
                            n_o_wp     = '0;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                if (wq_rsp.done) begin
                    n_valid    = 1'b1;
                    n_o_status = r_status;
                    n_o_item   = r_use_item ? r_item : '0;
                    n_o_wv     = wq_rsp.found;
                    n_o_wp     = wq_rsp.found ? wq_pid : '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[r_wslot] <= i_item_in;
        end
        if (st_re) begin
            r_item <= r_store[r_rslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wslot <= '0;
            r_rslot <= '0;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wslot <= n_wslot;
            r_rslot <= n_rslot;
            r_fill  <= n_fill;
            r_valid <= n_valid;
        end
        r_status   <= n_status;
        r_use_item <= n_use_item;
        r_o_status <= n_o_status;
        r_o_item   <= n_o_item;
        r_o_wv     <= n_o_wv;
        r_o_wp     <= n_o_wp;
    end

    bbw_waiters #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .PID_BITS   (PID_BITS)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (wq_cmd),
        .i_pid   (i_pid),
        .o_rsp   (wq_rsp),
        .o_pid   (wq_pid)
    );

    assign o_valid      = r_valid;
    assign o_status     = r_o_status;
    assign o_item_out   = r_o_item;
    assign o_wake_valid = r_o_wv;
    assign o_woken_pid  = r_o_wp;

endmodule

// ===== bench/tb.sv =====
// Testbench for the bounded buffer with waiter queues: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import bbw_pkg::*;

    localparam int RING  = RING_DEPTH_DEF;
    localparam int WAITQ = WAIT_DEPTH_DEF;
    localparam logic [1:0] REQ_UNDEF  = 2'd3;
    localparam logic       ST_DONE    = 1'b0;
    localparam logic       ST_BLOCKED = 1'b1;
    localparam logic signed [31:0] MAX_ITEM = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_ITEM = 32'sh8000_0000;

    typedef struct packed {
        logic              status;
        logic signed [31:0] item_out;
        logic              wake_valid;
        logic [7:0]        woken;
    } t_answer;

    typedef struct packed {
        logic [1:0]         req;
        logic [7:0]         pid;
        logic signed [31:0] item;
        logic               typed;
        t_answer            ans;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_req_type = '0;
    logic [7:0] i_pid = '0;
    logic signed [31:0] i_item_in = '0;
    logic o_valid;
    logic o_status;
    logic signed [31:0] o_item_out;
    logic o_wake_valid;
    logic [7:0] o_woken_pid;

    bounded_buffer_with_waiters_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_pid        (i_pid),
        .i_item_in    (i_item_in),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_item_out   (o_item_out),
        .o_wake_valid (o_wake_valid),
        .o_woken_pid  (o_woken_pid)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] ring [RING];
    logic [3:0] wr_slot = '0;
    logic [3:0] rd_slot = '0;
    int fill = 0;
    logic [7:0] space_q[$];
    logic [7:0] data_q[$];

    t_answer expected_answers[$];
    t_row rows[$];
    int errors = 0;
    int n_items = 0;
    int n_blocked = 0;
    int n_woken = 0;
    int n_queue_full = 0;
    int n_ring_full = 0;
    int n_removes = 0;
    bit idle_on = 1'b1;

    task automatic flag(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void park(ref logic [7:0] q[$], input logic [7:0] pid);
        foreach (q[i]) if (q[i] == pid) return;
        if (q.size() < WAITQ) q.push_back(pid);
        else n_queue_full++;
    endfunction

    function automatic void purge(ref logic [7:0] q[$], input logic [7:0] pid);
        logic [7:0] kept[$];
        foreach (q[i]) if (q[i] != pid) kept.push_back(q[i]);
        q = kept;
    endfunction

    function automatic t_answer serve_request(input logic [1:0] req, input logic [7:0] pid,
                                              input logic signed [31:0] item);
        t_answer a;
        a = '0;
        case (req)
            REQ_PRODUCE: begin
                if (fill >= RING) begin
                    park(space_q, pid);
                    a.status = ST_BLOCKED;
                    n_ring_full++;
                end else begin
                    ring[wr_slot] = item;
                    wr_slot++;
                    fill++;
                    if (data_q.size() != 0) begin
                        a.wake_valid = 1'b1;
                        a.woken = data_q.pop_front();
                    end
                end
            end
            REQ_CONSUME: begin
                if (fill == 0) begin
                    park(data_q, pid);
                    a.status = ST_BLOCKED;
                end else begin
                    a.item_out = ring[rd_slot];
                    rd_slot++;
                    fill--;
                    if (space_q.size() != 0) begin
                        a.wake_valid = 1'b1;
                        a.woken = space_q.pop_front();
                    end
                end
            end
            REQ_REMOVE: begin
                purge(space_q, pid);
                purge(data_q, pid);
                n_removes++;
            end
            default: ;
        endcase
        if (a.status == ST_BLOCKED) n_blocked++;
        if (a.wake_valid) n_woken++;
        return a;
    endfunction

    task automatic send(input t_row r);
        t_answer pred;
        while (idle_on && $urandom_range(99) < 22) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= r.req;
        i_pid      <= r.pid;
        i_item_in  <= r.item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = serve_request(r.req, r.pid, r.item);
        expected_answers.push_back(r.typed ? r.ans : pred);
        n_items++;
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_row mk(input logic [1:0] req, input logic [7:0] pid,
                                input logic signed [31:0] item, input logic typed,
                                input logic st, input logic signed [31:0] iout,
                                input logic wv, input logic [7:0] wp);
        t_row r;
        r.req = req;
        r.pid = pid;
        r.item = item;
        r.typed = typed;
        r.ans = '{status: st, item_out: iout, wake_valid: wv, woken: wp};
        return r;
    endfunction

    // outputs change on rising edges only; sample mid-cycle
    always @(negedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                flag("result with no request outstanding");
            end else begin
                e = expected_answers.pop_front();
                if (o_status !== e.status)
                    flag($sformatf("status %b, expected %b", o_status, e.status));
                if (o_item_out !== e.item_out)
                    flag($sformatf("item_out %h, expected %h", o_item_out, e.item_out));
                if (o_wake_valid !== e.wake_valid)
                    flag($sformatf("wake_valid %b, expected %b", o_wake_valid, e.wake_valid));
                if (o_woken_pid !== e.woken)
                    flag($sformatf("woken pid %h, expected %h", o_woken_pid, e.woken));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_answers.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_row r;
        int mode_left;
        bit produce_mode;
        logic [7:0] pool_base;
        int pool_sz;
        int pick;
        int drain;
        logic signed [31:0] extremes [4];

        extremes[0] = MAX_ITEM;
        extremes[1] = MIN_ITEM;
        extremes[2] = '0;
        extremes[3] = -32'sd1;

        rows.push_back(mk(REQ_CONSUME, 8'h00, 32'sd5, 1'b1, ST_BLOCKED, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'h00, 32'sd6, 1'b1, ST_BLOCKED, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'hFF, MAX_ITEM, 1'b1, ST_BLOCKED, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_REMOVE, 8'h42, MIN_ITEM, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_UNDEF, 8'hFF, MAX_ITEM, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_PRODUCE, 8'h01, MAX_ITEM, 1'b1, ST_DONE, 32'sd0, 1'b1, 8'h00));
        rows.push_back(mk(REQ_PRODUCE, 8'h02, MIN_ITEM, 1'b1, ST_DONE, 32'sd0, 1'b1, 8'hFF));
        rows.push_back(mk(REQ_PRODUCE, 8'h03, 32'sd0, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_PRODUCE, 8'hFF, -32'sd1, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'hAA, 32'sd0, 1'b1, ST_DONE, MAX_ITEM, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'hAA, 32'sd0, 1'b1, ST_DONE, MIN_ITEM, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'hAA, 32'sd0, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'hAA, 32'sd0, 1'b1, ST_DONE, -32'sd1, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'h55, 32'sd0, 1'b1, ST_BLOCKED, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'hAA, 32'sd0, 1'b1, ST_BLOCKED, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_REMOVE, 8'h55, 32'sd0, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_PRODUCE, 8'h10, 32'sh1234_5678, 1'b1, ST_DONE, 32'sd0, 1'b1,
                          8'hAA));
        rows.push_back(mk(REQ_UNDEF, 8'h00, 32'sd0, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_REMOVE, 8'h00, 32'sd0, 1'b1, ST_DONE, 32'sd0, 1'b0, 8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'h80, 32'sd0, 1'b1, ST_DONE, 32'sh1234_5678, 1'b0,
                          8'h00));
        rows.push_back(mk(REQ_PRODUCE, 8'h7F, 32'sh5A5A_5A5A, 1'b0, ST_DONE, 32'sd0, 1'b0,
                          8'h00));
        rows.push_back(mk(REQ_CONSUME, 8'h01, 32'sh0F0F_0F0F, 1'b0, ST_DONE, 32'sd0, 1'b0,
                          8'h00));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send(rows[i]);
        hold_until_drained();

        mode_left = 0;
        produce_mode = 1'b1;
        pool_base = '0;
        pool_sz = 8;
        for (int n = 0; n < 1350; n++) begin
            idle_on = (n < 400 || n >= 700);
            if (mode_left == 0) begin
                produce_mode = ~produce_mode;
                mode_left = $urandom_range(60, 20);
                pool_base = 8'($urandom);
                pool_sz = $urandom_range(40, 3);
                if (n == 600 || $urandom_range(9) < 3) hold_until_drained();
            end
            mode_left--;
            r = '0;
            r.pid = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(pool_base + $urandom_range(pool_sz - 1));
            r.item = ($urandom_range(9) == 0) ? extremes[2'($urandom_range(3))] : 32'($urandom);
            pick = $urandom_range(99);
            if (pick < 2) begin
                r.req = REQ_UNDEF;
            end else if (pick < 10) begin
                r.req = REQ_REMOVE;
                if ($urandom_range(3) != 0) begin
                    if (space_q.size() != 0 && (data_q.size() == 0 || $urandom_range(1)))
                        r.pid = space_q[$urandom_range(space_q.size() - 1)];
                    else if (data_q.size() != 0)
                        r.pid = data_q[$urandom_range(data_q.size() - 1)];
                end
            end else if (pick < 82) begin
                r.req = produce_mode ? REQ_PRODUCE : REQ_CONSUME;
            end else begin
                r.req = produce_mode ? REQ_CONSUME : REQ_PRODUCE;
            end
            send(r);
        end
        start <= 1'b0;

        drain = 0;
        while (expected_answers.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (50) @(posedge i_clk);
        foreach (expected_answers[i]) flag("expected result never arrived");

        $display("Ran %0d requests: %0d blocked, %0d wakes, %0d removes", n_items, n_blocked,
                 n_woken, n_removes);
        $display("Hit a full ring %0d times and a full waiter queue %0d times", n_ring_full,
                 n_queue_full);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
